// ===== design/postfix_expression_evaluator_core_macros.svh =====
// Assertion macros for the postfix evaluator RTL.
// Standalone header; the modules that assert include it, clocked on clk_i, reset rst_ni.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Invariant that must hold at every clock edge out of reset
`define PEE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle
`define PEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PEE_ASSERT(lbl, cond, msg)
`define PEE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/pee_pkg.sv =====
// Shared types, constants and codes of the postfix evaluator.
// No dependencies.
package pee_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned ANSWER_W    = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DEPTH_W-1:0]    depth_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Evaluator state; top and nxt cache the two upper stack entries
  typedef struct packed {
    value_t  top;
    value_t  nxt;
    value_t  acc;
    logic    in_num;
    depth_t  depth;
    status_e err;
  } eval_state_t;

  // Spill of the second entry into the stack memory
  typedef struct packed {
    logic   we;
    addr_t  addr;
    value_t data;
  } mem_wr_t;

  typedef struct packed {
    logic                fire;
    logic [ANSWER_W-1:0] answer;
    status_e             status;
  } result_t;

endpackage

// ===== design/pee_stack_ram.sv =====
// Generic single-write, single-read synchronous RAM with write-to-read bypass.
// No dependencies.
module pee_stack_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a same-cycle write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pee_exec.sv =====
// Next-state logic of the evaluator: character decode, number build, push and operator.
// Depends on pee_pkg.
module pee_exec import pee_pkg::*; (
  input  logic              accept_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  eval_state_t       cur_i,
  input  value_t            third_i,   // stack entry below nxt, from the memory
  output eval_state_t       nxt_o,
  output mem_wr_t           wr_o,
  output result_t           res_o
);

  logic        is_digit, is_blank, is_op, is_mul, is_nl;
  logic [3:0]  digit;
  value_t      acc_dig;
  logic        flush, push_ok, push_ovf;
  depth_t      d1;
  value_t      t1, n1, n2, op_res;
  status_e     err1, fin_status;

  // Character classes
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_blank = (char_code_i == CH_BLANK);
  assign is_mul   = (char_code_i == CH_STAR);
  assign is_op    = is_mul || (char_code_i == CH_PLUS);
  assign is_nl    = (char_code_i == CH_NEWLINE);
  assign digit    = 4'(char_code_i - CH_ZERO);

  // acc * 10 + digit, wrapping
  assign acc_dig = (cur_i.acc << 3) + (cur_i.acc << 1) + value_t'(digit);

  // Pending number pushed ahead of blank, operator or newline
  assign flush    = cur_i.in_num && (is_blank || is_op || is_nl);
  assign push_ok  = flush && (cur_i.depth < DEPTH_W'(STACK_DEPTH));
  assign push_ovf = flush && !push_ok;
  assign d1       = push_ok ? cur_i.depth + DEPTH_W'(1) : cur_i.depth;

  // Stack view after the push
  assign t1 = push_ok ? cur_i.acc : cur_i.top;
  assign n1 = push_ok ? cur_i.top : cur_i.nxt;
  assign n2 = push_ok ? cur_i.nxt : third_i;

  assign err1   = (cur_i.err != ST_OK) ? cur_i.err : (push_ovf ? ST_OVER : ST_OK);
  assign op_res = is_mul ? value_t'(t1 * n1) : (t1 + n1);

  assign fin_status = (err1 != ST_OK) ? err1 : ((d1 == '0) ? ST_EMPTY : ST_OK);

  always_comb begin
    nxt_o   = cur_i;
    wr_o    = '{we: 1'b0, addr: addr_t'(cur_i.depth - DEPTH_W'(2)), data: cur_i.nxt};
    res_o   = '{fire: 1'b0, answer: '0, status: ST_OK};
    if (accept_i) begin
      if (is_digit) begin
        nxt_o.acc    = acc_dig;
        nxt_o.in_num = 1'b1;
      end else if (is_blank) begin
        nxt_o.acc    = '0;
        nxt_o.in_num = 1'b0;
        nxt_o.err    = err1;
        if (push_ok) begin
          nxt_o.top   = t1;
          nxt_o.nxt   = n1;
          nxt_o.depth = d1;
          // old second entry moves down into memory
          wr_o.we     = (cur_i.depth >= DEPTH_W'(2));
        end
      end else if (is_op) begin
        nxt_o.acc    = '0;
        nxt_o.in_num = 1'b0;
        if (d1 < DEPTH_W'(2)) begin
          // underflow: stack kept as it stands after the push
          nxt_o.top   = t1;
          nxt_o.nxt   = n1;
          nxt_o.depth = d1;
          nxt_o.err   = (err1 != ST_OK) ? err1 : ST_UNDER;
        end else begin
          nxt_o.top   = op_res;
          nxt_o.nxt   = n2;
          nxt_o.depth = d1 - DEPTH_W'(1);
          nxt_o.err   = err1;
        end
      end else if (is_nl) begin
        res_o.fire   = 1'b1;
        res_o.status = fin_status;
        res_o.answer = (fin_status == ST_OK) ? ANSWER_W'($signed(t1)) : '0;
        nxt_o.acc    = '0;
        nxt_o.in_num = 1'b0;
        nxt_o.depth  = '0;
        nxt_o.err    = ST_OK;
      end
    end
  end

endmodule

// ===== design/postfix_expression_evaluator_core.sv =====
// Postfix expression evaluator: one ASCII character per cycle, result per newline.
// Answer and status are registered and appear on the output register in the cycle after the newline is taken.
// Throughput: one character per cycle; the top two entries sit in registers and the rest
// of the stack in a synchronous RAM that is prefetched at the next depth.
// Input stalls only while a result is held and the output side stalls.
// Reset clears depth, number, error and output valid; the stack RAM is not cleared.
`include "postfix_expression_evaluator_core_macros.svh"

module postfix_expression_evaluator_core import pee_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CHAR_W-1:0]   char_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ANSWER_W-1:0] answer_o,
  output logic [1:0]          status_o
);

  eval_state_t         st_q, st_d;
  mem_wr_t             wr;
  result_t             res;
  value_t              third;
  addr_t               raddr;
  logic                in_acc;
  logic                nl_acc;
  logic                out_valid_q;
  logic [ANSWER_W-1:0] answer_q;
  status_e             status_q;

  // Input handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign nl_acc     = in_acc && (char_code_i == CH_NEWLINE);

  pee_exec u_exec (
    .accept_i    (in_acc),
    .char_code_i (char_code_i),
    .cur_i       (st_q),
    .third_i     (third),
    .nxt_o       (st_d),
    .wr_o        (wr),
    .res_o       (res)
  );

  // Prefetch the entry below the second at the next depth
  assign raddr = addr_t'(st_d.depth - DEPTH_W'(3));

  pee_stack_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (third)
  );

  // Evaluator state, cached top entries included
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.top    <= '0;
      st_q.nxt    <= '0;
      st_q.acc    <= '0;
      st_q.in_num <= 1'b0;
      st_q.depth  <= '0;
      st_q.err    <= ST_OK;
    end else begin
      st_q        <= st_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= res.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.fire) begin
      answer_q <= res.answer;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;
  assign status_o    = status_q;

  // Checks
  `PEE_ASSERT(a_depth_bound, st_q.depth <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")
  `PEE_ASSERT_NEXT(a_nl_result, nl_acc, out_valid_q, "newline without result")
  `PEE_ASSERT_NEXT(a_nl_clear, nl_acc, ~|{st_q.depth, st_q.in_num, st_q.err}, "state kept")
  `PEE_ASSERT(a_err_answer, !out_valid_q || status_q == ST_OK || answer_q == '0, "bad answer")
  `PEE_ASSERT_NEXT(a_err_sticky, (st_q.err != ST_OK) && !nl_acc, $stable(st_q.err), "error lost")

endmodule

// ===== dv/postfix_expression_evaluator_core_tb.sv =====
// Self-checking testbench for postfix_expression_evaluator_core: character streams in,
// answer/status checked per newline against a predictor kept in a small scoreboard class.
// Depends on pee_pkg and the evaluator core RTL.
`timescale 1ns / 100ps

module postfix_expression_evaluator_core_tb;
  import pee_pkg::*;

  localparam int unsigned DECIMAL_BASE = 10;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Expected answer of one expression
  typedef struct packed {
    logic [ANSWER_W-1:0] answer;
    status_e             status;
  } answer_rec_t;

  // Predictor of the evaluator plus the queue of answers still due
  class postfix_predictor;
    value_t      stack_q [STACK_DEPTH];
    int unsigned depth;
    value_t      acc;
    bit          in_num;
    status_e     err;
    answer_rec_t answers_due [$];
    int unsigned mismatches;

    function new();
      depth      = 0;
      acc        = '0;
      in_num     = 1'b0;
      err        = ST_OK;
      mismatches = 0;
    endfunction

    // Errors are sticky: only the first one per expression is kept
    function void raise(status_e code);
      if (err == ST_OK) err = code;
    endfunction

    function void take_char(logic [CHAR_W-1:0] c);
      answer_rec_t rec;
      value_t      lhs;
      value_t      rhs;
      bit          is_digit;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (is_digit) begin
        acc    = value_t'(acc * value_t'(DECIMAL_BASE) + value_t'(c - CH_ZERO));
        in_num = 1'b1;
        return;
      end
      if (c != CH_BLANK && c != CH_PLUS && c != CH_STAR && c != CH_NEWLINE) return;
      // any separator or operator pushes a pending number first
      if (in_num) begin
        if (depth >= STACK_DEPTH) begin
          raise(ST_OVER);
        end else begin
          stack_q[depth] = acc;
          depth++;
        end
      end
      acc    = '0;
      in_num = 1'b0;
      if (c == CH_PLUS || c == CH_STAR) begin
        if (depth < 2) begin
          raise(ST_UNDER);
        end else begin
          lhs = stack_q[depth-1];
          rhs = stack_q[depth-2];
          depth--;
          stack_q[depth-1] = (c == CH_STAR) ? value_t'(lhs * rhs) : value_t'(lhs + rhs);
        end
      end else if (c == CH_NEWLINE) begin
        rec.answer = '0;
        if (err != ST_OK) begin
          rec.status = err;
        end else if (depth == 0) begin
          rec.status = ST_EMPTY;
        end else begin
          rec.status = ST_OK;
          rec.answer = ANSWER_W'($signed(stack_q[depth-1]));
        end
        answers_due.push_back(rec);
        depth = 0;
        err   = ST_OK;
      end
    endfunction

    function void check_answer(logic [ANSWER_W-1:0] answer, logic [1:0] status);
      answer_rec_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result answer %h status %0d", $realtime, answer, status);
        return;
      end
      want = answers_due.pop_front();
      if (answer !== want.answer || status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: expected answer %h status %0d, got answer %h status %0d",
                   $realtime, want.answer, want.status, answer, status);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [CHAR_W-1:0]   char_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ANSWER_W-1:0] answer_o;
  logic [1:0]          status_o;

  int unsigned      send_idle_pct = 24;
  int unsigned      recv_idle_pct = 72;
  int unsigned      tokens_sent   = 0;
  postfix_predictor predictor;

  postfix_expression_evaluator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .answer_o   (answer_o),
    .status_o   (status_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Random output back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) predictor.check_answer(answer_o, status_o);
  end

  function automatic bit is_token(logic [CHAR_W-1:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || c == CH_BLANK || c == CH_PLUS ||
           c == CH_STAR || c == CH_NEWLINE;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
    return CH_ZERO + CHAR_W'(d);
  endfunction

  // A byte the evaluator ignores
  function automatic logic [CHAR_W-1:0] noise_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255)); while (is_token(c));
    return c;
  endfunction

  // One request: random gap, then hold until accepted
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    predictor.take_char(c);
    if (is_token(c)) tokens_sent++;
  endtask

  task automatic send_blanks();
    int unsigned n;
    n = ($urandom_range(99) < 75) ? 1 : $urandom_range(3, 2);
    repeat (n) send_char(CH_BLANK);
  endtask

  task automatic send_op();
    send_char($urandom_range(1) ? CH_PLUS : CH_STAR);
  endtask

  // Mostly short numbers, a few long enough to wrap
  task automatic send_number();
    int unsigned ndig;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)      ndig = $urandom_range(3, 1);
    else if (pick < 90) ndig = $urandom_range(10, 4);
    else                ndig = $urandom_range(20, 11);
    for (int unsigned i = 0; i < ndig; i++) begin
      if ($urandom_range(99) < 3) send_char(noise_char());
      send_char(digit_char($urandom_range(9)));
    end
  endtask

  // One expression: n_push numbers, operators mixed in at op_pct, extra_ops surplus operators
  task automatic send_expression(input int unsigned n_push, input int unsigned extra_ops,
                                 input int unsigned op_pct);
    int unsigned live;
    live = 0;
    for (int unsigned i = 0; i < n_push; i++) begin
      send_number();
      live++;
      if (live >= 2 && $urandom_range(99) < op_pct) begin
        if ($urandom_range(1)) send_blanks();
        do begin
          send_op();
          live--;
          if ($urandom_range(1)) send_blanks();
        end while (live >= 2 && $urandom_range(99) < op_pct);
      end else if (i + 1 < n_push || $urandom_range(1)) begin
        send_blanks();
      end
    end
    // reduce what is left, usually to one value
    while (live >= 2 && $urandom_range(99) < 90) begin
      send_op();
      live--;
      if ($urandom_range(1)) send_blanks();
    end
    repeat (extra_ops) send_op();
    if ($urandom_range(99) < 20) send_blanks();
    send_char(CH_NEWLINE);
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned quota);
    int unsigned pick;
    int unsigned goal;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    goal = tokens_sent + quota;
    while (tokens_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_expression(($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(16, 7),
                        0, $urandom_range(90, 20));
      end else if (pick < 83) begin
        // too many operators
        send_expression($urandom_range(3, 0), $urandom_range(2, 1), $urandom_range(90, 20));
      end else if (pick < 90) begin
        // more numbers than the stack holds
        send_expression($urandom_range(20, STACK_DEPTH + 1), 0, 0);
      end else if (pick < 94) begin
        send_expression(0, 0, 0);
      end else begin
        repeat ($urandom_range(8, 1)) send_char(CHAR_W'($urandom_range(255)));
      end
    end
  endtask

  // Watchdog
  initial begin
    #2_000_000;
    $display("postfix_expression_evaluator_core_tb: done, errors");
    $finish;
  end

  // Main sequence
  initial begin
    predictor = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty line, then an operator on an empty stack
    send_char(CH_NEWLINE);
    send_char(CH_PLUS);
    send_char(CH_NEWLINE);
    // star right after digits, doubled blanks, an ignored byte, plus right after digits
    send_char(digit_char(9));
    send_char(CH_BLANK);
    send_char(digit_char(9));
    send_char(CH_STAR);
    send_char(CH_BLANK);
    send_char(CH_BLANK);
    send_char(8'hFF);
    send_char(digit_char(7));
    send_char(CH_PLUS);
    send_char(CH_NEWLINE);
    // two values left, the second pending at the newline
    send_char(digit_char(5));
    send_char(CH_BLANK);
    send_char(digit_char(6));
    send_char(CH_NEWLINE);
    // ignored bytes, underflow, then a value that must not clear the error
    send_char(8'h00);
    send_char(8'h80);
    send_char(CH_STAR);
    send_char(digit_char(3));
    send_char(CH_NEWLINE);

    run_phase(24, 72, 330);
    run_phase(72, 24, 330);
    run_phase(0, 0, 340);
    in_valid_i <= 1'b0;

    while (predictor.answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predictor.mismatches == 0 && predictor.answers_due.size() == 0) begin
      $display("postfix_expression_evaluator_core_tb: done, clean");
    end else begin
      $display("postfix_expression_evaluator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
